// ----- rtl/wf3_pkg.sv -----
`default_nettype none

package wf3_pkg;

  localparam int PIX_W     = 8;
  localparam int COEF_W    = 16;
  localparam int TAPS      = 3;
  localparam int KROW_W    = COEF_W * TAPS;
  localparam int SIZE_W    = 11;
  localparam int SZ_CMP_W  = 13;   // holds sizes up to 4096
  localparam int RES_W     = 28;
  localparam int COORD_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = KROW_W;
  localparam int MIN_SIZE  = 5;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // products and partial sums
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int RSUM_W = PROD_W + 2;
  localparam int TSUM_W = RSUM_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KROW_TOP = 3'd0,
    REG_KROW_MID = 3'd1,
    REG_KROW_BOT = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } cfg_reg_e;

endpackage

`default_nettype wire

// ----- rtl/wf3_if.sv -----
`default_nettype none

interface wf3_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [wf3_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface wf3_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [wf3_pkg::RES_W-1:0]  filtered;
  logic [wf3_pkg::COORD_W-1:0]       out_row;
  logic [wf3_pkg::COORD_W-1:0]       out_col;
  logic                              frame_end;

  modport source (output valid, output filtered, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input filtered, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/window_filter_3x3_top.sv -----
`default_nettype none

// 3x3 convolution over a raster pixel stream. Pixels come in row by row, one
// word per clock at full rate while the output is not stalled; a result word
// leaves for every pixel that completes a 3x3 window (row >= 2 and col >= 2),
// carrying the sum of the nine coefficient*pixel products (no kernel flip),
// the window's top-left coordinates and a frame_end mark on the frame's last
// result. From pixel accept to result valid a word passes the registered
// line-store read, nine multipliers, per-row sums and final sum into the
// output register. The pipeline stages each hold their own word, so a stalled
// output only backs up as far as the first empty stage. Both line stores share
// one MAX_WIDTH-deep memory of {older,newer} pixel pairs with one read and one
// write port. After reset the memory is swept to zero, one entry per clock, so
// the pixel port stays not-ready until the sweep is done; configuration writes
// are taken during that time. Image width/height are clamped to [5, MAX_WIDTH]
// and [5, MAX_HEIGHT]. Change configuration only while the pipeline is empty.
module window_filter_3x3_top #(
  parameter int MAX_WIDTH  = wf3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = wf3_pkg::DEF_MAX_HEIGHT
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [wf3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [wf3_pkg::CFG_W-1:0]       cfg_data_i,
  wf3_pixel_if.sink                      pix_i,
  wf3_result_if.source                   res_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = wf3_pkg::PIX_W;
  localparam int SW = wf3_pkg::SZ_CMP_W;
  localparam int T  = wf3_pkg::TAPS;

  // ---------------- configuration registers ----------------
  logic [wf3_pkg::KROW_W-1:0] krow_q [T];
  logic [wf3_pkg::SIZE_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < T; i++) krow_q[i] <= '0;
      width_q  <= wf3_pkg::SIZE_RESET;
      height_q <= wf3_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wf3_pkg::REG_KROW_TOP: krow_q[0] <= cfg_data_i;
        wf3_pkg::REG_KROW_MID: krow_q[1] <= cfg_data_i;
        wf3_pkg::REG_KROW_BOT: krow_q[2] <= cfg_data_i;
        wf3_pkg::REG_WIDTH:    width_q   <= cfg_data_i[wf3_pkg::SIZE_W-1:0];
        wf3_pkg::REG_HEIGHT:   height_q  <= cfg_data_i[wf3_pkg::SIZE_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // effective (clamped) frame size
  logic [SW-1:0] w_eff, h_eff;

  always_comb begin
    w_eff = SW'(width_q);
    if (w_eff < SW'(wf3_pkg::MIN_SIZE)) w_eff = SW'(wf3_pkg::MIN_SIZE);
    else if (w_eff > SW'(MAX_WIDTH))    w_eff = SW'(MAX_WIDTH);
    h_eff = SW'(height_q);
    if (h_eff < SW'(wf3_pkg::MIN_SIZE)) h_eff = SW'(wf3_pkg::MIN_SIZE);
    else if (h_eff > SW'(MAX_HEIGHT))   h_eff = SW'(MAX_HEIGHT);
  end

  // ---------------- pipeline handshake ----------------
  logic v1_q, v2_q, v3_q, res_v_q;
  logic take1, take2, take3, take_out;
  logic clr_q;
  logic in_acc;

  // each stage loads when it is empty or its word moves on
  assign take_out = !res_v_q || res_o.ready;
  assign take3    = !v3_q || take_out;
  assign take2    = !v2_q || take3;
  assign take1    = !v1_q || take2;

  assign pix_i.ready = take1 && !clr_q;
  assign in_acc      = pix_i.valid && pix_i.ready;

  // ---------------- position counters (stage 0) ----------------
  logic [CW-1:0] col_cnt_q;
  logic [RW-1:0] row_cnt_q;
  logic [SW-1:0] c_ext, r_ext;
  logic          last_col, last_row;
  logic          emit0, fend0;
  logic [15:0]   row_m2, col_m2;

  always_comb begin
    c_ext    = SW'(col_cnt_q);
    r_ext    = SW'(row_cnt_q);
    last_col = (c_ext + SW'(1)) >= w_eff;
    last_row = (r_ext + SW'(1)) >= h_eff;
    emit0    = (r_ext >= SW'(2)) && (c_ext >= SW'(2));
    fend0    = (r_ext == h_eff - SW'(1)) && (c_ext == w_eff - SW'(1));
    row_m2   = 16'(row_cnt_q) - 16'd2;
    col_m2   = 16'(col_cnt_q) - 16'd2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_cnt_q <= '0;
        row_cnt_q <= last_row ? '0 : row_cnt_q + 1'b1;
      end else begin
        col_cnt_q <= col_cnt_q + 1'b1;
      end
    end
  end

  // ---------------- line stores + reset sweep ----------------
  logic [CW-1:0]   clr_addr_q;
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_q;       // {older, newer} at the accepted column
  logic            mem_we;
  logic [CW-1:0]   mem_waddr;
  logic [2*PW-1:0] mem_wdata;

  logic [PW-1:0]   pix1_q;
  logic [CW-1:0]   ci1_q;
  logic            emit1_q, fend1_q;
  logic [wf3_pkg::COORD_W-1:0] row1_q, col1_q;
  logic            s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == CW'(MAX_WIDTH - 1)) clr_q <= 1'b0;
    end
  end

  // stage-1 word leaving: write back its column and shift the window
  assign s1_move = v1_q && take2;

  always_comb begin
    mem_we    = clr_q || s1_move;
    mem_waddr = clr_q ? clr_addr_q : ci1_q;
    mem_wdata = clr_q ? '0 : {rd_q[PW-1:0], pix1_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    if (in_acc) rd_q <= line_mem[col_cnt_q];
  end

  // ---------------- stage 1: window and multipliers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (take1) v1_q <= in_acc;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix1_q  <= pix_i.pixel;
      ci1_q   <= col_cnt_q;
      emit1_q <= emit0;
      fend1_q <= fend0;
      row1_q  <= row_m2[wf3_pkg::COORD_W-1:0];
      col1_q  <= col_m2[wf3_pkg::COORD_W-1:0];
    end
  end

  logic [PW-1:0] cur [T];
  logic [PW-1:0] wc1_q [T];    // column col-1
  logic [PW-1:0] wc2_q [T];    // column col-2

  assign cur[0] = rd_q[2*PW-1:PW];
  assign cur[1] = rd_q[PW-1:0];
  assign cur[2] = pix1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < T; i++) begin
        wc1_q[i] <= '0;
        wc2_q[i] <= '0;
      end
    end else if (s1_move) begin
      for (int i = 0; i < T; i++) begin
        wc2_q[i] <= wc1_q[i];
        wc1_q[i] <= cur[i];
      end
    end
  end

  logic signed [wf3_pkg::PROD_W-1:0] prod_d [T][T];
  logic signed [wf3_pkg::PROD_W-1:0] prod_q [T][T];
  logic signed [wf3_pkg::COEF_W-1:0] k_ij;
  logic [PW-1:0]                     p_ij;

  always_comb begin
    k_ij = '0;
    p_ij = '0;
    for (int i = 0; i < T; i++) begin
      for (int j = 0; j < T; j++) begin
        k_ij = $signed(krow_q[i][wf3_pkg::COEF_W*j +: wf3_pkg::COEF_W]);
        p_ij = (j == 0) ? wc2_q[i] : ((j == 1) ? wc1_q[i] : cur[i]);
        prod_d[i][j] = wf3_pkg::PROD_W'(k_ij * $signed({1'b0, p_ij}));
      end
    end
  end

  // ---------------- stage 2: products ----------------
  logic fend2_q;
  logic [wf3_pkg::COORD_W-1:0] row2_q, col2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (take2) v2_q <= v1_q && emit1_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      prod_q  <= prod_d;
      fend2_q <= fend1_q;
      row2_q  <= row1_q;
      col2_q  <= col1_q;
    end
  end

  // ---------------- stage 3: per-row sums ----------------
  logic signed [wf3_pkg::RSUM_W-1:0] rsum_q [T];
  logic fend3_q;
  logic [wf3_pkg::COORD_W-1:0] row3_q, col3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (take3) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (take3 && v2_q) begin
      for (int i = 0; i < T; i++) begin
        rsum_q[i] <= wf3_pkg::RSUM_W'(prod_q[i][0]) + wf3_pkg::RSUM_W'(prod_q[i][1])
                   + wf3_pkg::RSUM_W'(prod_q[i][2]);
      end
      fend3_q <= fend2_q;
      row3_q  <= row2_q;
      col3_q  <= col2_q;
    end
  end

  // ---------------- output register ----------------
  logic signed [wf3_pkg::TSUM_W-1:0] tsum;
  logic signed [wf3_pkg::RES_W-1:0]  res_filt_q;
  logic [wf3_pkg::COORD_W-1:0]       res_row_q, res_col_q;
  logic                              res_fend_q;

  assign tsum = wf3_pkg::TSUM_W'(rsum_q[0]) + wf3_pkg::TSUM_W'(rsum_q[1])
              + wf3_pkg::TSUM_W'(rsum_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_v_q <= 1'b0;
    else if (take_out) res_v_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (take_out && v3_q) begin
      res_filt_q <= tsum[wf3_pkg::RES_W-1:0];  // sum is known to fit
      res_row_q  <= row3_q;
      res_col_q  <= col3_q;
      res_fend_q <= fend3_q;
    end
  end

  assign res_o.valid     = res_v_q;
  assign res_o.filtered  = res_filt_q;
  assign res_o.out_row   = res_row_q;
  assign res_o.out_col   = res_col_q;
  assign res_o.frame_end = res_fend_q;

  // ---------------- assertions ----------------
  // no pixel may reach the line store while the sweep still owns the write port
  a_no_item_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !v1_q && !v2_q && !v3_q)
    else $error("pipeline word present during line store sweep");

  // a new result only ever comes from a filled sum stage
  a_res_from_s3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_v_q) |-> $past(v3_q))
    else $error("result valid without a word in the sum stage");

  // column counter stays inside the line store
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (SW'(col_cnt_q) < SW'(MAX_WIDTH)))
    else $error("column counter beyond line store depth");

endmodule

`default_nettype wire

// ----- verif/window_filter_3x3_top_tb.sv -----
`default_nettype none

module window_filter_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX  = wf3_pkg::DEF_MAX_WIDTH;
  localparam int ROWS_MAX  = wf3_pkg::DEF_MAX_HEIGHT;
  localparam int DRAIN_CYC = 8;        // drain margin, longer than the pipeline
  localparam int RAND_PIX  = 1800;

  // Kernel rows with every tap at one extreme; nine taps of -32768 against
  // pixels of 255 give the most negative sum the block can produce.
  localparam logic [wf3_pkg::KROW_W-1:0] KROW_ALL_NEG = 48'h8000_8000_8000;
  localparam logic [wf3_pkg::KROW_W-1:0] KROW_ALL_POS = 48'h7FFF_7FFF_7FFF;
  localparam logic signed [wf3_pkg::RES_W-1:0] SUM_FLOOR = -28'sd75202560;

  typedef struct packed {
    logic signed [wf3_pkg::RES_W-1:0] sum;
    logic [wf3_pkg::COORD_W-1:0]      row;
    logic [wf3_pkg::COORD_W-1:0]      col;
    logic                             last;
  } window_sum_t;

  // One row of the opening sequence: a pixel, and where the answer is plain
  // to see, the result word it must produce.
  typedef struct {
    logic [wf3_pkg::PIX_W-1:0]        pix;
    bit                               typed;
    logic signed [wf3_pkg::RES_W-1:0] sum;
    logic [wf3_pkg::COORD_W-1:0]      row;
    logic [wf3_pkg::COORD_W-1:0]      col;
    logic                             last;
  } opening_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we;
  wf3_pkg::cfg_reg_e           cfg_idx;
  logic [wf3_pkg::CFG_W-1:0]   cfg_data;

  wf3_pixel_if  pix_if ();
  wf3_result_if res_if ();

  window_filter_3x3_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  // ---------------------------------------------------------------------------
  // Clock: 20 ns period.
  // ---------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the filter: kernel, frame size, both line stores, the two
  // trailing window columns and the raster position of the next pixel.
  // ---------------------------------------------------------------------------
  logic [wf3_pkg::KROW_W-1:0] kern_rows [wf3_pkg::TAPS];
  logic [wf3_pkg::SIZE_W-1:0] img_w;
  logic [wf3_pkg::SIZE_W-1:0] img_h;
  logic [wf3_pkg::PIX_W-1:0]  line_older [LINE_MAX];
  logic [wf3_pkg::PIX_W-1:0]  line_newer [LINE_MAX];
  logic [wf3_pkg::PIX_W-1:0]  win_cols [6];   // [0..2] column c-1, [3..5] column c-2
  int unsigned                col_pos;
  int unsigned                row_pos;

  window_sum_t        window_sums_q [$];   // sums owed by the block, oldest first

  int                 tx_idle_pct;
  int                 rx_stall_pct;
  int                 pixels_sent;
  int                 sums_seen;
  int                 bad_sums;
  int                 settings_run;

  // Run one accepted pixel through the shadow filter. Returns 1 when the pixel
  // closes a full 3x3 window, with the word the block owes in sum_o.
  function automatic bit convolve_pixel(input logic [wf3_pkg::PIX_W-1:0] pix,
                                        output window_sum_t sum_o);
    int unsigned               w;
    int unsigned               h;
    int unsigned               c;
    int unsigned               r;
    int unsigned               ci;
    int                        i;
    logic [wf3_pkg::PIX_W-1:0] col_now [3];
    longint                    acc;

    w = (img_w < wf3_pkg::MIN_SIZE) ? wf3_pkg::MIN_SIZE
      : (img_w > LINE_MAX) ? LINE_MAX : img_w;
    h = (img_h < wf3_pkg::MIN_SIZE) ? wf3_pkg::MIN_SIZE
      : (img_h > ROWS_MAX) ? ROWS_MAX : img_h;
    c = col_pos;
    r = row_pos;
    ci = (c < LINE_MAX) ? c : LINE_MAX - 1;
    col_now[0] = line_older[ci];
    col_now[1] = line_newer[ci];
    col_now[2] = pix;
    sum_o = '0;
    convolve_pixel = 1'b0;

    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (i = 0; i < wf3_pkg::TAPS; i++) begin
        acc += longint'($signed(kern_rows[i][15:0]))  * longint'(win_cols[3 + i]);
        acc += longint'($signed(kern_rows[i][31:16])) * longint'(win_cols[i]);
        acc += longint'($signed(kern_rows[i][47:32])) * longint'(col_now[i]);
      end
      sum_o.sum  = acc[wf3_pkg::RES_W-1:0];
      sum_o.row  = wf3_pkg::COORD_W'(r - 2);
      sum_o.col  = wf3_pkg::COORD_W'(c - 2);
      sum_o.last = (r == h - 1) && (c == w - 1);
      convolve_pixel = 1'b1;
    end

    for (i = 0; i < 3; i++) begin
      win_cols[3 + i] = win_cols[i];
      win_cols[i]     = col_now[i];
    end
    line_older[ci] = col_now[1];
    line_newer[ci] = col_now[2];

    // a shrunk size leaves the counters where they are; they wrap on the next pixel
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Writes go back to back; the caller drops the enable.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input wf3_pkg::cfg_reg_e idx,
                           input logic [wf3_pkg::CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    case (idx)
      wf3_pkg::REG_KROW_TOP: kern_rows[0] = val;
      wf3_pkg::REG_KROW_MID: kern_rows[1] = val;
      wf3_pkg::REG_KROW_BOT: kern_rows[2] = val;
      wf3_pkg::REG_WIDTH:    img_w = val[wf3_pkg::SIZE_W-1:0];
      wf3_pkg::REG_HEIGHT:   img_h = val[wf3_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [wf3_pkg::KROW_W-1:0] k0,
                               input logic [wf3_pkg::KROW_W-1:0] k1,
                               input logic [wf3_pkg::KROW_W-1:0] k2,
                               input logic [wf3_pkg::SIZE_W-1:0] w,
                               input logic [wf3_pkg::SIZE_W-1:0] h);
    write_reg(wf3_pkg::REG_KROW_TOP, k0);
    write_reg(wf3_pkg::REG_KROW_MID, k1);
    write_reg(wf3_pkg::REG_KROW_BOT, k2);
    write_reg(wf3_pkg::REG_WIDTH, wf3_pkg::CFG_W'(w));
    write_reg(wf3_pkg::REG_HEIGHT, wf3_pkg::CFG_W'(h));
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Pixel sender. Valid is driven once per clock edge: it stays high straight
  // into the next word unless an idle gap is drawn.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [wf3_pkg::PIX_W-1:0] pix, input bit typed,
                            input window_sum_t typed_sum);
    window_sum_t owed;
    bit          hit;

    while ($urandom_range(0, 99) < tx_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= pix;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    pixels_sent++;
    hit = convolve_pixel(pix, owed);
    if (hit) window_sums_q.push_back(typed ? typed_sum : owed);
  endtask

  // Hold the sender until every owed sum is out, then let the pipeline settle.
  task automatic wait_for_sums();
    pix_if.valid <= 1'b0;
    while (window_sums_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic set_traffic(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 76; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 76; end
      default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
    endcase
  endtask

  function automatic logic [wf3_pkg::KROW_W-1:0] pick_krow(input int kind);
    case (kind)
      0: pick_krow = KROW_ALL_NEG;
      1: pick_krow = KROW_ALL_POS;
      2: pick_krow = '0;
      default: pick_krow = wf3_pkg::KROW_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [wf3_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: pick_pixel = '0;
      1: pick_pixel = '1;
      default: pick_pixel = wf3_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and every taken word checked against
  // the oldest owed sum.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic flag_sum(input string what, input window_sum_t want,
                          input window_sum_t got);
    bad_sums++;
    if (bad_sums <= 10)
      $display("ERROR %s: want sum %0d row %0d col %0d end %0b, %s %0d row %0d col %0d end %0b",
               what, want.sum, want.row, want.col, want.last,
               "got sum", got.sum, got.row, got.col, got.last);
  endtask

  always @(posedge clk_i) begin : sum_check
    window_sum_t got;
    window_sum_t want;

    if (rst_ni && res_if.valid && res_if.ready) begin
      got.sum  = res_if.filtered;
      got.row  = res_if.out_row;
      got.col  = res_if.out_col;
      got.last = res_if.frame_end;
      sums_seen++;
      if (window_sums_q.size() == 0) begin
        flag_sum("result word with nothing owed", '0, got);
      end else begin
        want = window_sums_q.pop_front();
        if (got.sum !== want.sum || got.row !== want.row ||
            got.col !== want.col || got.last !== want.last)
          flag_sum($sformatf("result word %0d", sums_seen), want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Opening sequence: one 5x5 frame against an all -32768 kernel. The top three
  // rows are saturated, so the first row of results sits at the negative
  // floor; the bottom rows mix in zeros and odd values, and the last pixel
  // closes the frame.
  // ---------------------------------------------------------------------------
  opening_row_t opening [25] = '{
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b1, SUM_FLOOR, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b1, SUM_FLOOR, 10'd0, 10'd1, 1'b0},
    '{8'd255, 1'b1, SUM_FLOOR, 10'd0, 10'd2, 1'b0},
    '{8'd0,   1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd128, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd1,   1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd254, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd127, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd0,   1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd0,   1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd255, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd85,  1'b0, 28'sd0, 10'd0, 10'd0, 1'b0},
    '{8'd170, 1'b0, 28'sd0, 10'd0, 10'd0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                         k;
    int                         n;
    int                         pause_at;
    int                         phase;
    int                         kind;
    int                         rand_pixels;
    logic [wf3_pkg::SIZE_W-1:0] w;
    logic [wf3_pkg::SIZE_W-1:0] h;
    window_sum_t                typed_sum;

    // every input known from time zero
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = wf3_pkg::REG_KROW_TOP;
    cfg_data     = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    pixels_sent  = 0;
    sums_seen    = 0;
    bad_sums     = 0;
    settings_run = 0;

    // shadow state at its reset values
    foreach (kern_rows[i]) kern_rows[i] = '0;
    foreach (line_older[i]) line_older[i] = '0;
    foreach (line_newer[i]) line_newer[i] = '0;
    foreach (win_cols[i]) win_cols[i] = '0;
    img_w   = wf3_pkg::SIZE_RESET;
    img_h   = wf3_pkg::SIZE_RESET;
    col_pos = 0;
    row_pos = 0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Settings go in while the line memory is still being swept; the pixel
    // port just stays not-ready until the sweep is done.
    set_traffic(0);
    load_settings(KROW_ALL_NEG, KROW_ALL_NEG, KROW_ALL_NEG, 11'd5, 11'd5);
    foreach (opening[i]) begin
      typed_sum.sum  = opening[i].sum;
      typed_sum.row  = opening[i].row;
      typed_sum.col  = opening[i].col;
      typed_sum.last = opening[i].last;
      send_pixel(opening[i].pix, opening[i].typed, typed_sum);
    end
    wait_for_sums();

    // Random part. Each phase picks a traffic shape, a kernel style and a
    // frame size, then streams a random run of pixels. Runs stop mid-frame on
    // purpose, so the next size change exercises the counter wrap. Phase two
    // is the one full-width pass: a whole row fills the newer line store to
    // its last entry, and the narrow frame after it reads its low entries back.
    phase       = 0;
    rand_pixels = 0;
    while (rand_pixels < RAND_PIX) begin
      set_traffic(phase % 4);
      kind = $urandom_range(0, 9);

      if (phase == 2) begin
        w = 11'd2047;               // clamps to the store depth
        h = 11'd1024;
        n = LINE_MAX + $urandom_range(20, 60);
      end else begin
        w = ($urandom_range(0, 3) == 0) ? wf3_pkg::SIZE_W'($urandom_range(0, 4))
                                        : wf3_pkg::SIZE_W'($urandom_range(5, 12));
        case ($urandom_range(0, 7))
          0:       h = wf3_pkg::SIZE_W'($urandom_range(0, 4));
          1:       h = ($urandom_range(0, 1) == 0) ? 11'd2047
                                        : wf3_pkg::SIZE_W'($urandom_range(1025, 2046));
          default: h = wf3_pkg::SIZE_W'($urandom_range(5, 9));
        endcase
        n = $urandom_range(20, 150);
      end
      load_settings(pick_krow(kind), pick_krow(kind), pick_krow(kind), w, h);

      // now and then hold the sender mid-run until the pipeline runs dry
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : -1;
      for (k = 0; k < n; k++) begin
        if (k == pause_at) wait_for_sums();
        send_pixel(pick_pixel(), 1'b0, '0);
      end
      rand_pixels += n;
      wait_for_sums();
      phase++;
    end

    $display("Streamed %0d pixels under %0d kernel/size settings; %0d window sums checked",
             pixels_sent, settings_run, sums_seen);
    $display("Traffic mixed free flow, sparse sender, heavy back-pressure and both at once");
    if (bad_sums == 0 && window_sums_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d bad result words, %0d sums still owed", bad_sums, window_sums_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("Timeout with %0d sums still owed", window_sums_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
